FILE: rtl/core/wrhp_pkg.sv
package wrhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [9:0]  MS_PER_S        = 10'd1000;
    localparam logic [4:0]  FMT_CAPTURE_LEN = 5'd16;
    localparam logic [4:0]  WORD_LAST_BYTE  = 5'd3;
    localparam logic [31:0] WAVE_TAG_BYTES  = 32'd4;

    localparam int unsigned QUOT_W = 42;
    localparam int unsigned DIV_STEPS = QUOT_W;

    localparam logic KIND_PCM     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_RIFF  = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_NO_FORMAT = 3'd3,
        ST_NO_DATA   = 3'd4,
        ST_TRUNCATED = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_RIFF_TAG  = 3'd0,
        PH_RIFF_SIZE = 3'd1,
        PH_WAVE_TAG  = 3'd2,
        PH_CHUNK_TAG = 3'd3,
        PH_CHUNK_LEN = 3'd4,
        PH_PAYLOAD   = 3'd5,
        PH_PAD       = 3'd6,
        PH_DONE      = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE     = 2'd0,
        SEQ_DIV_LOAD = 2'd1,
        SEQ_DIV_RUN  = 2'd2,
        SEQ_EMIT     = 2'd3
    } seq_t;

    typedef struct packed {
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits;
        logic [31:0] data_size;
    } held_t;

    typedef struct packed {
        logic    pcm_fire;
        logic    sum_fire;
        status_t status;
    } parse_evt_t;

endpackage

FILE: rtl/core/wrhp_div.sv
module wrhp_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [31:0]                  data_size,
    input  logic [31:0]                  divisor,
    output logic                         done,
    output logic [wrhp_pkg::QUOT_W-1:0]  quotient
);

    localparam int unsigned CNT_W = $clog2(wrhp_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wrhp_pkg::DIV_STEPS - 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [wrhp_pkg::QUOT_W-1:0] quo_reg;
    logic [31:0]                 rem_reg;

    logic [wrhp_pkg::QUOT_W-1:0] product;
    logic [32:0]                 trial;
    logic [32:0]                 diff;
    logic                        ge;
    logic [31:0]                 rem_next;

    assign product  = {10'd0, data_size} * {32'd0, wrhp_pkg::MS_PER_S};
    assign trial    = {rem_reg, quo_reg[wrhp_pkg::QUOT_W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign ge       = trial >= {1'b0, divisor};
    // The remainder always stays below the divisor, so 32 bits hold it.
    assign rem_next = ge ? diff[31:0] : trial[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= product;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[wrhp_pkg::QUOT_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/wrhp_parser.sv
module wrhp_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  logic [7:0]           byte_value,
    input  logic                 start_of_file,
    input  logic                 end_of_stream,
    output wrhp_pkg::parse_evt_t evt,
    output wrhp_pkg::held_t      held
);

    wrhp_pkg::phase_t phase_reg, phase_b, phase_next;
    logic [4:0]       fbc_reg, fbc_b, fbc_next;
    logic [31:0]      ws_reg, ws_b, ws_next;
    logic [31:0]      riff_reg, riff_b, riff_next;
    logic [31:0]      tag_reg, tag_b, tag_next;
    logic [31:0]      left_reg, left_b, left_next;
    logic             pad_reg, pad_b, pad_next;
    logic             fmt_seen_reg, fmt_seen_b, fmt_seen_next;
    wrhp_pkg::held_t  held_reg, held_b, held_next;

    always_comb begin
        logic do_end;
        logic do_next;
        logic [3:0] pos;

        do_end  = 1'b0;
        do_next = 1'b0;

        // A start-of-file word resets the parser before the byte is taken.
        if (start_of_file) begin
            phase_b    = wrhp_pkg::PH_RIFF_TAG;
            fbc_b      = '0;
            ws_b       = '0;
            riff_b     = '0;
            tag_b      = '0;
            left_b     = '0;
            pad_b      = 1'b0;
            fmt_seen_b = 1'b0;
            held_b     = '0;
        end else begin
            phase_b    = phase_reg;
            fbc_b      = fbc_reg;
            ws_b       = ws_reg;
            riff_b     = riff_reg;
            tag_b      = tag_reg;
            left_b     = left_reg;
            pad_b      = pad_reg;
            fmt_seen_b = fmt_seen_reg;
            held_b     = held_reg;
        end

        pos           = fbc_b[3:0];
        phase_next    = phase_b;
        fbc_next      = fbc_b;
        ws_next       = ws_b;
        riff_next     = riff_b;
        tag_next      = tag_b;
        left_next     = left_b;
        pad_next      = pad_b;
        fmt_seen_next = fmt_seen_b;
        held_next     = held_b;
        evt           = '{pcm_fire: 1'b0, sum_fire: 1'b0, status: wrhp_pkg::ST_OK};

        unique case (phase_b)
            wrhp_pkg::PH_RIFF_TAG, wrhp_pkg::PH_RIFF_SIZE, wrhp_pkg::PH_WAVE_TAG,
            wrhp_pkg::PH_CHUNK_TAG, wrhp_pkg::PH_CHUNK_LEN: begin
                if ((phase_b == wrhp_pkg::PH_CHUNK_TAG || phase_b == wrhp_pkg::PH_CHUNK_LEN)
                    && riff_b != '0) begin
                    riff_next = riff_b - 1'b1;
                end
                ws_next = {byte_value, ws_b[31:8]};
                if (fbc_b < wrhp_pkg::WORD_LAST_BYTE) begin
                    fbc_next = fbc_b + 1'b1;
                end else begin
                    fbc_next = '0;
                    case (phase_b)
                        wrhp_pkg::PH_RIFF_TAG: begin
                            if (ws_next != wrhp_pkg::TAG_RIFF) begin
                                evt.sum_fire = 1'b1;
                                evt.status   = wrhp_pkg::ST_NOT_RIFF;
                                phase_next   = wrhp_pkg::PH_DONE;
                            end else begin
                                phase_next = wrhp_pkg::PH_RIFF_SIZE;
                            end
                        end
                        wrhp_pkg::PH_RIFF_SIZE: begin
                            riff_next  = (ws_next >= wrhp_pkg::WAVE_TAG_BYTES) ?
                                         ws_next - wrhp_pkg::WAVE_TAG_BYTES : '0;
                            phase_next = wrhp_pkg::PH_WAVE_TAG;
                        end
                        wrhp_pkg::PH_WAVE_TAG: begin
                            if (ws_next != wrhp_pkg::TAG_WAVE) begin
                                evt.sum_fire = 1'b1;
                                evt.status   = wrhp_pkg::ST_NOT_WAVE;
                                phase_next   = wrhp_pkg::PH_DONE;
                            end else begin
                                do_next = 1'b1;
                            end
                        end
                        wrhp_pkg::PH_CHUNK_TAG: begin
                            tag_next   = ws_next;
                            phase_next = wrhp_pkg::PH_CHUNK_LEN;
                        end
                        default: begin
                            left_next = ws_next;
                            pad_next  = ws_next[0];
                            if (tag_b == wrhp_pkg::TAG_FMT) begin
                                fmt_seen_next = 1'b1;
                            end
                            if (tag_b == wrhp_pkg::TAG_DATA) begin
                                held_next.data_size = ws_next;
                            end
                            if (ws_next == '0) begin
                                do_end = 1'b1;
                            end else begin
                                phase_next = wrhp_pkg::PH_PAYLOAD;
                            end
                        end
                    endcase
                end
            end
            wrhp_pkg::PH_PAYLOAD: begin
                if (riff_b != '0) begin
                    riff_next = riff_b - 1'b1;
                end
                if (tag_b == wrhp_pkg::TAG_FMT && fbc_b < wrhp_pkg::FMT_CAPTURE_LEN) begin
                    case (pos) inside
                        [4'd0:4'd1]:   held_next.format_tag[8*pos[0] +: 8] = byte_value;
                        [4'd2:4'd3]:   held_next.channels[8*pos[0] +: 8] = byte_value;
                        [4'd4:4'd7]:   held_next.sample_rate[8*pos[1:0] +: 8] = byte_value;
                        [4'd8:4'd11]:  held_next.byte_rate[8*pos[1:0] +: 8] = byte_value;
                        [4'd12:4'd13]: held_next.block_align[8*pos[0] +: 8] = byte_value;
                        default:       held_next.bits[8*pos[0] +: 8] = byte_value;
                    endcase
                    fbc_next = fbc_b + 1'b1;
                end else if (tag_b == wrhp_pkg::TAG_DATA) begin
                    evt.pcm_fire = 1'b1;
                end
                left_next = left_b - 1'b1;
                if (left_next == '0) begin
                    do_end = 1'b1;
                end
            end
            wrhp_pkg::PH_PAD: begin
                if (riff_b != '0) begin
                    riff_next = riff_b - 1'b1;
                end
                do_next = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_end) begin
            if (tag_next == wrhp_pkg::TAG_DATA && held_next.data_size != '0) begin
                evt.sum_fire = 1'b1;
                evt.status   = (fmt_seen_next && held_next.byte_rate != '0) ?
                               wrhp_pkg::ST_OK : wrhp_pkg::ST_NO_FORMAT;
                phase_next   = wrhp_pkg::PH_DONE;
            end else if (pad_next) begin
                phase_next = wrhp_pkg::PH_PAD;
            end else begin
                do_next = 1'b1;
            end
        end

        if (do_next) begin
            if (riff_next == '0) begin
                evt.sum_fire = 1'b1;
                evt.status   = wrhp_pkg::ST_NO_DATA;
                phase_next   = wrhp_pkg::PH_DONE;
            end else begin
                phase_next = wrhp_pkg::PH_CHUNK_TAG;
                fbc_next   = '0;
            end
        end

        if (end_of_stream && phase_next != wrhp_pkg::PH_DONE) begin
            evt.sum_fire = 1'b1;
            evt.status   = wrhp_pkg::ST_TRUNCATED;
            phase_next   = wrhp_pkg::PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= wrhp_pkg::PH_RIFF_TAG;
            fbc_reg      <= '0;
            ws_reg       <= '0;
            riff_reg     <= '0;
            tag_reg      <= '0;
            left_reg     <= '0;
            pad_reg      <= 1'b0;
            fmt_seen_reg <= 1'b0;
            held_reg     <= '0;
        end else if (take) begin
            phase_reg    <= phase_next;
            fbc_reg      <= fbc_next;
            ws_reg       <= ws_next;
            riff_reg     <= riff_next;
            tag_reg      <= tag_next;
            left_reg     <= left_next;
            pad_reg      <= pad_next;
            fmt_seen_reg <= fmt_seen_next;
            held_reg     <= held_next;
        end
    end

    assign held = held_reg;

endmodule

FILE: rtl/core/wav_riff_header_parser_core.sv
// Channel | Direction | Ports                                      | Handshake
// s_      | in        | byte_value, start_of_file, end_of_stream   | s_valid / s_ready
// m_      | out       | kind, pcm_byte, fmt fields, data_size,     | m_valid / m_ready
//         |           | duration_ms, status, last                  |
// Header, pad and PCM words are taken while s_ready is high; a PCM result sits in the output register.
// A summary with good status first loads the 32x10 product into the bit-serial divider,
// then waits for its 42 restoring steps before it is emitted.
// A summary with an error status goes from its word through SEQ_EMIT into the output register.
// Reset is synchronous on aresetn; s_ready drops while a summary is pending
// and whenever the output register is full and m_ready is low.
module wav_riff_header_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_start_of_file,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_pcm_byte,
    output logic [15:0] m_format_tag,
    output logic [15:0] m_channel_count,
    output logic [31:0] m_sample_rate,
    output logic [31:0] m_avg_bytes_per_second,
    output logic [15:0] m_block_align,
    output logic [15:0] m_bits_per_sample,
    output logic [31:0] m_data_size,
    output logic [41:0] m_duration_ms,
    output logic [2:0]  m_status,
    output logic        m_last
);

    wrhp_pkg::seq_t       seq_reg, seq_next;
    wrhp_pkg::status_t    status_reg, status_next;
    logic                 m_valid_reg, m_valid_next;
    wrhp_pkg::parse_evt_t evt;
    wrhp_pkg::held_t      held;
    logic                 take;
    logic                 out_free;
    logic                 load_pcm;
    logic                 load_sum;
    logic                 div_start;
    logic                 div_done;
    logic [wrhp_pkg::QUOT_W-1:0] quotient;

    logic        kind_reg;
    logic [7:0]  pcm_reg;
    logic [15:0] fmt_tag_reg;
    logic [15:0] chan_reg;
    logic [31:0] rate_reg;
    logic [31:0] bps_reg;
    logic [15:0] align_reg;
    logic [15:0] bits_reg;
    logic [31:0] size_reg;
    logic [41:0] dur_reg;
    logic [2:0]  stat_reg;
    logic        last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (seq_reg == wrhp_pkg::SEQ_IDLE) && out_free;
    assign take     = s_valid && s_ready;

    wrhp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .byte_value    (s_byte_value),
        .start_of_file (s_start_of_file),
        .end_of_stream (s_end_of_stream),
        .evt           (evt),
        .held          (held)
    );

    wrhp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .data_size (held.data_size),
        .divisor   (held.byte_rate),
        .done      (div_done),
        .quotient  (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= wrhp_pkg::SEQ_IDLE;
            status_reg  <= wrhp_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            seq_reg     <= seq_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        seq_next    = seq_reg;
        status_next = status_reg;
        load_pcm    = 1'b0;
        load_sum    = 1'b0;
        div_start   = 1'b0;
        unique case (seq_reg)
            wrhp_pkg::SEQ_IDLE: begin
                if (take) begin
                    load_pcm = evt.pcm_fire;
                    if (evt.sum_fire) begin
                        status_next = evt.status;
                        seq_next    = (evt.status == wrhp_pkg::ST_OK) ?
                                      wrhp_pkg::SEQ_DIV_LOAD : wrhp_pkg::SEQ_EMIT;
                    end
                end
            end
            wrhp_pkg::SEQ_DIV_LOAD: begin
                // Held fields settle at the accepting edge, so the divider starts from this load state.
                div_start = 1'b1;
                seq_next  = wrhp_pkg::SEQ_DIV_RUN;
            end
            wrhp_pkg::SEQ_DIV_RUN: begin
                if (div_done) begin
                    seq_next = wrhp_pkg::SEQ_EMIT;
                end
            end
            wrhp_pkg::SEQ_EMIT: begin
                if (out_free) begin
                    load_sum = 1'b1;
                    seq_next = wrhp_pkg::SEQ_IDLE;
                end
            end
            default: begin
                seq_next = wrhp_pkg::SEQ_IDLE;
            end
        endcase
        if (load_pcm || load_sum) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_pcm) begin
            kind_reg    <= wrhp_pkg::KIND_PCM;
            pcm_reg     <= s_byte_value;
            fmt_tag_reg <= '0;
            chan_reg    <= '0;
            rate_reg    <= '0;
            bps_reg     <= '0;
            align_reg   <= '0;
            bits_reg    <= '0;
            size_reg    <= '0;
            dur_reg     <= '0;
            stat_reg    <= wrhp_pkg::ST_OK;
            last_reg    <= 1'b0;
        end else if (load_sum) begin
            kind_reg    <= wrhp_pkg::KIND_SUMMARY;
            pcm_reg     <= '0;
            fmt_tag_reg <= held.format_tag;
            chan_reg    <= held.channels;
            rate_reg    <= held.sample_rate;
            bps_reg     <= held.byte_rate;
            align_reg   <= held.block_align;
            bits_reg    <= held.bits;
            size_reg    <= held.data_size;
            dur_reg     <= (status_reg == wrhp_pkg::ST_OK) ? quotient : '0;
            stat_reg    <= status_reg;
            last_reg    <= 1'b1;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_kind                 = kind_reg;
    assign m_pcm_byte             = pcm_reg;
    assign m_format_tag           = fmt_tag_reg;
    assign m_channel_count        = chan_reg;
    assign m_sample_rate          = rate_reg;
    assign m_avg_bytes_per_second = bps_reg;
    assign m_block_align          = align_reg;
    assign m_bits_per_sample      = bits_reg;
    assign m_data_size            = size_reg;
    assign m_duration_ms          = dur_reg;
    assign m_status               = stat_reg;
    assign m_last                 = last_reg;

    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> seq_reg == wrhp_pkg::SEQ_DIV_RUN)
        else $error("divider finished outside its run phase");

    a_ok_goes_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        take && evt.sum_fire && evt.status == wrhp_pkg::ST_OK
        |=> seq_reg == wrhp_pkg::SEQ_DIV_LOAD)
        else $error("good summary did not start the divider");

    a_emit_loads_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == wrhp_pkg::SEQ_EMIT && out_free
        |=> m_valid && m_kind == wrhp_pkg::KIND_SUMMARY && m_last)
        else $error("summary word not loaded on emit");

endmodule

FILE: tb/sv/wav_stream_checker.sv
module wav_stream_checker
    import wrhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_start_of_file,
    input  logic        s_end_of_stream,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [7:0]  m_pcm_byte,
    input  logic [15:0] m_format_tag,
    input  logic [15:0] m_channel_count,
    input  logic [31:0] m_sample_rate,
    input  logic [31:0] m_avg_bytes_per_second,
    input  logic [15:0] m_block_align,
    input  logic [15:0] m_bits_per_sample,
    input  logic [31:0] m_data_size,
    input  logic [41:0] m_duration_ms,
    input  logic [2:0]  m_status,
    input  logic        m_last,
    output int          fail_count,
    output int          pending_results
);

    typedef struct packed {
        logic        kind;
        logic [7:0]  pcm;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits;
        logic [31:0] data_size;
        logic [41:0] duration;
        logic [2:0]  status;
        logic        last;
    } wav_result_t;

    wav_result_t awaited_results[$];
    wav_result_t want;

    // Shadow copy of the parser state.
    phase_t      phase;
    logic [4:0]  byte_count;
    logic [31:0] word_shift;
    logic [31:0] riff_left;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_left;
    logic        pad_pending;
    logic        fmt_seen;
    held_t       held;
    logic        file_done;

    initial begin
        fail_count = 0;
        pending_results = 0;
    end

    task clear_parser();
        phase       = PH_RIFF_TAG;
        byte_count  = '0;
        word_shift  = '0;
        riff_left   = '0;
        chunk_tag   = '0;
        chunk_left  = '0;
        pad_pending = 1'b0;
        fmt_seen    = 1'b0;
        held        = '0;
        file_done   = 1'b0;
    endtask

    task queue_pcm(input logic [7:0] value);
        wav_result_t r;
        r = '0;
        r.kind = KIND_PCM;
        r.pcm = value;
        awaited_results.push_back(r);
    endtask

    task queue_summary(input status_t st);
        wav_result_t r;
        logic [63:0] quot;
        r = '0;
        r.kind        = KIND_SUMMARY;
        r.format_tag  = held.format_tag;
        r.channels    = held.channels;
        r.sample_rate = held.sample_rate;
        r.byte_rate   = held.byte_rate;
        r.block_align = held.block_align;
        r.bits        = held.bits;
        r.data_size   = held.data_size;
        if (st == ST_OK && held.byte_rate != 0) begin
            quot = ({32'd0, held.data_size} * 64'(MS_PER_S)) / {32'd0, held.byte_rate};
            r.duration = quot[41:0];
        end
        r.status = st;
        r.last   = 1'b1;
        awaited_results.push_back(r);
        phase     = PH_DONE;
        file_done = 1'b1;
    endtask

    task open_next_chunk();
        if (riff_left == 0) begin
            queue_summary(ST_NO_DATA);
        end else begin
            phase = PH_CHUNK_TAG;
            byte_count = '0;
        end
    endtask

    task close_payload();
        if (chunk_tag == TAG_DATA && held.data_size != 0) begin
            if (fmt_seen && held.byte_rate != 0)
                queue_summary(ST_OK);
            else
                queue_summary(ST_NO_FORMAT);
        end else if (pad_pending) begin
            phase = PH_PAD;
        end else begin
            open_next_chunk();
        end
    endtask

    // The fmt payload is laid out as 16-bit halves: tag, channels, rate (two),
    // byte rate (two), block align, bits.
    task capture_fmt(input logic [4:0] pos, input logic [7:0] value);
        case (pos[3:1])
            3'd0: held.format_tag[{pos[0], 3'b000} +: 8] = value;
            3'd1: held.channels[{pos[0], 3'b000} +: 8] = value;
            3'd2, 3'd3: held.sample_rate[{pos[1:0], 3'b000} +: 8] = value;
            3'd4, 3'd5: held.byte_rate[{pos[1:0], 3'b000} +: 8] = value;
            3'd6: held.block_align[{pos[0], 3'b000} +: 8] = value;
            default: held.bits[{pos[0], 3'b000} +: 8] = value;
        endcase
    endtask

    task parse_byte(input logic [7:0] value);
        logic [31:0] w;
        if (phase <= PH_CHUNK_LEN) begin
            if (phase >= PH_CHUNK_TAG && riff_left != 0)
                riff_left--;
            word_shift = {value, word_shift[31:8]};
            byte_count++;
            if (byte_count > WORD_LAST_BYTE) begin
                byte_count = '0;
                w = word_shift;
                case (phase)
                    PH_RIFF_TAG: begin
                        if (w != TAG_RIFF)
                            queue_summary(ST_NOT_RIFF);
                        else
                            phase = PH_RIFF_SIZE;
                    end
                    PH_RIFF_SIZE: begin
                        riff_left = (w >= WAVE_TAG_BYTES) ? w - WAVE_TAG_BYTES : 32'd0;
                        phase = PH_WAVE_TAG;
                    end
                    PH_WAVE_TAG: begin
                        if (w != TAG_WAVE)
                            queue_summary(ST_NOT_WAVE);
                        else
                            open_next_chunk();
                    end
                    PH_CHUNK_TAG: begin
                        chunk_tag = w;
                        phase = PH_CHUNK_LEN;
                    end
                    default: begin
                        chunk_left = w;
                        pad_pending = w[0];
                        if (chunk_tag == TAG_FMT)
                            fmt_seen = 1'b1;
                        if (chunk_tag == TAG_DATA)
                            held.data_size = w;
                        if (w == 0)
                            close_payload();
                        else
                            phase = PH_PAYLOAD;
                    end
                endcase
            end
        end else if (phase == PH_PAYLOAD) begin
            if (riff_left != 0)
                riff_left--;
            if (chunk_tag == TAG_FMT && byte_count < FMT_CAPTURE_LEN) begin
                capture_fmt(byte_count, value);
                byte_count++;
            end else if (chunk_tag == TAG_DATA) begin
                queue_pcm(value);
            end
            chunk_left--;
            if (chunk_left == 0)
                close_payload();
        end else if (phase == PH_PAD) begin
            if (riff_left != 0)
                riff_left--;
            open_next_chunk();
        end
    endtask

    task check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            awaited_results.delete();
        end else begin
            // Results are compared before this edge's word is predicted, so a stray
            // result can never be matched against a brand new expectation.
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with nothing expected: kind %0b status %0d",
                           m_kind, m_status);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("pcm_byte", want.pcm, m_pcm_byte);
                    check_field("format_tag", want.format_tag, m_format_tag);
                    check_field("channel_count", want.channels, m_channel_count);
                    check_field("sample_rate", want.sample_rate, m_sample_rate);
                    check_field("avg_bytes_per_second", want.byte_rate,
                                m_avg_bytes_per_second);
                    check_field("block_align", want.block_align, m_block_align);
                    check_field("bits_per_sample", want.bits, m_bits_per_sample);
                    check_field("data_size", want.data_size, m_data_size);
                    check_field("duration_ms", want.duration, m_duration_ms);
                    check_field("status", want.status, m_status);
                    check_field("last", want.last, m_last);
                end
            end
            if (s_valid && s_ready) begin
                if (s_start_of_file)
                    clear_parser();
                if (!file_done)
                    parse_byte(s_byte_value);
                if (s_end_of_stream && !file_done)
                    queue_summary(ST_TRUNCATED);
            end
        end
        pending_results = awaited_results.size();
    end

endmodule

FILE: tb/sv/wav_riff_header_parser_core_tb.sv
module wav_riff_header_parser_core_tb;
    import wrhp_pkg::*;

    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_WORDS = 450;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [7:0] value;
        logic       sof;
        logic       eos;
    } stim_word_t;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_PATTERN, RDY_SPARSE} ready_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = '0;
    logic        s_start_of_file = 1'b0;
    logic        s_end_of_stream = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [7:0]  m_pcm_byte;
    logic [15:0] m_format_tag;
    logic [15:0] m_channel_count;
    logic [31:0] m_sample_rate;
    logic [31:0] m_avg_bytes_per_second;
    logic [15:0] m_block_align;
    logic [15:0] m_bits_per_sample;
    logic [31:0] m_data_size;
    logic [41:0] m_duration_ms;
    logic [2:0]  m_status;
    logic        m_last;
    int          fail_count;
    int          pending_results;

    logic [7:0]  file_bytes[$];
    stim_word_t  stim_q[$];
    stim_word_t  cur_word;
    int          burst_left = 0;
    int          gap_left = 0;
    ready_mode_t rdy_mode = RDY_ALWAYS;
    int          rdy_left = 0;
    logic [31:0] rdy_pattern = '0;

    always #5 aclk = ~aclk;

    wav_riff_header_parser_core i_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_byte_value           (s_byte_value),
        .s_start_of_file        (s_start_of_file),
        .s_end_of_stream        (s_end_of_stream),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_kind                 (m_kind),
        .m_pcm_byte             (m_pcm_byte),
        .m_format_tag           (m_format_tag),
        .m_channel_count        (m_channel_count),
        .m_sample_rate          (m_sample_rate),
        .m_avg_bytes_per_second (m_avg_bytes_per_second),
        .m_block_align          (m_block_align),
        .m_bits_per_sample      (m_bits_per_sample),
        .m_data_size            (m_data_size),
        .m_duration_ms          (m_duration_ms),
        .m_status               (m_status),
        .m_last                 (m_last)
    );

    wav_stream_checker i_checker (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_byte_value           (s_byte_value),
        .s_start_of_file        (s_start_of_file),
        .s_end_of_stream        (s_end_of_stream),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_kind                 (m_kind),
        .m_pcm_byte             (m_pcm_byte),
        .m_format_tag           (m_format_tag),
        .m_channel_count        (m_channel_count),
        .m_sample_rate          (m_sample_rate),
        .m_avg_bytes_per_second (m_avg_bytes_per_second),
        .m_block_align          (m_block_align),
        .m_bits_per_sample      (m_bits_per_sample),
        .m_data_size            (m_data_size),
        .m_duration_ms          (m_duration_ms),
        .m_status               (m_status),
        .m_last                 (m_last),
        .fail_count             (fail_count),
        .pending_results        (pending_results)
    );

    task add_u32(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endtask

    task add_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom));
    endtask

    task start_file(input logic [31:0] riff_tag, input logic [31:0] wave_tag);
        file_bytes.delete();
        add_u32(riff_tag);
        add_u32(32'd0);
        add_u32(wave_tag);
    endtask

    task set_riff_size(input logic [31:0] size);
        for (int i = 0; i < 4; i++)
            file_bytes[4 + i] = size[8*i +: 8];
    endtask

    task set_exact_size();
        set_riff_size(32'(file_bytes.size() - 8));
    endtask

    // Unknown chunk: header, random payload and a pad byte when the length is odd.
    task add_chunk(input logic [31:0] tag, input int len);
        add_u32(tag);
        add_u32(32'(len));
        add_random_bytes(len + (len % 2));
    endtask

    // The image holds the 16 fmt bytes with byte 0 in the low bits.
    task add_fmt(input int len, input logic [127:0] image);
        add_u32(TAG_FMT);
        add_u32(32'(len));
        for (int i = 0; i < len; i++)
            file_bytes.push_back((i < 16) ? image[8*i +: 8] : 8'($urandom));
        if (len % 2)
            add_random_bytes(1);
    endtask

    task add_data(input int len);
        add_u32(TAG_DATA);
        add_u32(32'(len));
        add_random_bytes(len);
    endtask

    task queue_file(input bit with_sof, input int eos_at);
        for (int i = 0; i < file_bytes.size(); i++)
            stim_q.push_back('{value: file_bytes[i], sof: with_sof && i == 0,
                               eos: i == eos_at});
    endtask

    function automatic logic [127:0] random_fmt();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task directed_files();
        int eos_idx;
        // A plain stereo file, right after reset and without a start marker.
        start_file(TAG_RIFF, TAG_WAVE);
        add_fmt(16, {16'd16, 16'd4, 32'd176400, 32'd44100, 16'd2, 16'd1});
        add_data(4);
        set_exact_size();
        queue_file(1'b0, -1);
        // A fact chunk and an odd unknown chunk come first; fields at their maximum,
        // a byte rate of one and an odd data length.
        start_file(TAG_RIFF, TAG_WAVE);
        add_chunk(TAG_FACT, 4);
        add_chunk(32'hFFFF_FFFF, 3);
        add_fmt(18, {16'hFFFF, 16'hFFFF, 32'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
        add_data(5);
        set_exact_size();
        queue_file(1'b1, -1);
        start_file(32'h5846_4952, TAG_WAVE);
        queue_file(1'b1, -1);
        start_file(TAG_RIFF, 32'h0000_0000);
        queue_file(1'b1, -1);
        // A RIFF size below four leaves nothing for chunks.
        start_file(TAG_RIFF, TAG_WAVE);
        add_data(2);
        set_riff_size(32'd2);
        queue_file(1'b1, -1);
        // The fmt chunk runs past the RIFF budget, which is then empty.
        start_file(TAG_RIFF, TAG_WAVE);
        add_fmt(16, random_fmt());
        add_data(3);
        set_riff_size(32'd16);
        queue_file(1'b1, -1);
        // Data without any fmt chunk.
        start_file(TAG_RIFF, TAG_WAVE);
        add_data(3);
        set_exact_size();
        queue_file(1'b1, -1);
        // Zero byte rate.
        start_file(TAG_RIFF, TAG_WAVE);
        add_fmt(16, {16'd8, 16'd1, 32'd0, 32'd8000, 16'd1, 16'd1});
        add_data(2);
        set_exact_size();
        queue_file(1'b1, -1);
        // Empty data chunk is skipped, the next one counts; largest byte rate.
        start_file(TAG_RIFF, TAG_WAVE);
        add_fmt(16, {16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0});
        add_data(0);
        add_data(3);
        set_exact_size();
        queue_file(1'b1, -1);
        // A short second fmt chunk overwrites only its first bytes.
        start_file(TAG_RIFF, TAG_WAVE);
        add_fmt(16, random_fmt());
        add_fmt(5, random_fmt());
        add_data(2);
        set_exact_size();
        queue_file(1'b1, -1);
        // Stream ends inside the fmt header.
        start_file(TAG_RIFF, TAG_WAVE);
        add_fmt(16, random_fmt());
        add_data(2);
        set_exact_size();
        queue_file(1'b1, 14);
        // Stream ends on a PCM byte before the data chunk is complete.
        start_file(TAG_RIFF, TAG_WAVE);
        add_fmt(16, random_fmt());
        add_data(6);
        set_exact_size();
        queue_file(1'b1, file_bytes.size() - 3);
        // End marker on the final data byte, then bytes and another marker after it.
        start_file(TAG_RIFF, TAG_WAVE);
        add_fmt(16, random_fmt());
        add_data(2);
        eos_idx = file_bytes.size() - 1;
        set_exact_size();
        add_random_bytes(3);
        queue_file(1'b1, eos_idx);
        stim_q.push_back('{value: 8'($urandom), sof: 1'b0, eos: 1'b1});
    endtask

    task random_file();
        int roll;
        logic [127:0] image;
        int eos_at;
        int flen;
        file_bytes.delete();
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            add_random_bytes($urandom_range(1, 12));
        end else begin
            start_file((roll < 8) ? 32'($urandom) : TAG_RIFF,
                       (roll >= 8 && roll < 11) ? 32'($urandom) : TAG_WAVE);
            repeat ($urandom_range(0, 2))
                add_chunk(($urandom_range(0, 2) == 0) ? TAG_FACT : 32'($urandom),
                          $urandom_range(0, 9));
            if ($urandom_range(0, 9) != 0) begin
                image = random_fmt();
                case ($urandom_range(0, 9))
                    0: image[95:64] = 32'd0;
                    1: image[95:64] = 32'd1;
                    2: image[95:64] = 32'hFFFF_FFFF;
                    3: image[95:64] = 32'($urandom_range(1, 1000));
                    default: ;
                endcase
                roll = $urandom_range(0, 99);
                flen = (roll < 70) ? 16 : (roll < 85) ? 18 : $urandom_range(0, 20);
                add_fmt(flen, image);
            end
            if ($urandom_range(0, 19) == 0)
                add_fmt($urandom_range(1, 15), random_fmt());
            if ($urandom_range(0, 19) == 0)
                add_data(0);
            if ($urandom_range(0, 9) == 0)
                add_chunk(32'($urandom), $urandom_range(0, 7));
            add_data(($urandom_range(0, 29) == 0) ? $urandom_range(25, 300)
                                                   : $urandom_range(1, 24));
            if ($urandom_range(0, 4) == 0)
                add_random_bytes($urandom_range(1, 3));
            roll = $urandom_range(0, 9);
            if (roll < 8)
                set_exact_size();
            else if (roll == 8)
                set_riff_size(32'($urandom_range(0, 40)));
            else
                set_riff_size(32'($urandom));
        end
        roll = $urandom_range(0, 9);
        if (roll == 0)
            eos_at = $urandom_range(0, file_bytes.size() - 1);
        else if (roll == 1)
            eos_at = file_bytes.size() - 1;
        else
            eos_at = -1;
        queue_file($urandom_range(0, 32) != 0, eos_at);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (stim_q.size() != 0) begin
                cur_word = stim_q.pop_front();
                s_byte_value    <= cur_word.value;
                s_start_of_file <= cur_word.sof;
                s_end_of_stream <= cur_word.eos;
                s_valid <= 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 32);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: gap_left = 0;
                        9: gap_left = $urandom_range(5, 20);
                        default: gap_left = $urandom_range(1, 4);
                    endcase
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches at random between ready styles.
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = ready_mode_t'($urandom_range(0, 3));
            rdy_left = $urandom_range(8, 64);
            rdy_pattern = $urandom;
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_COIN: m_ready <= 1'($urandom_range(0, 1));
            RDY_PATTERN: begin
                m_ready <= rdy_pattern[0];
                rdy_pattern = {rdy_pattern[0], rdy_pattern[31:1]};
            end
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(negedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int directed_words;
        directed_files();
        directed_words = stim_q.size();
        while (stim_q.size() < directed_words + RANDOM_WORDS)
            random_file();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        do
            @(negedge aclk);
        while (stim_q.size() != 0 || s_valid || pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
